>>> hw/rtl/upts_pkg.sv
// Shared types, constants and UTF-8 decode helpers for the pretoken splitter.
`default_nettype none

package upts_pkg;

    // request kinds on the input stream
    localparam logic [1:0] FUNC_TEXT   = 2'd0;
    localparam logic [1:0] FUNC_LETTER = 2'd1;
    localparam logic [1:0] FUNC_NUMBER = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_LETTER_COUNT = 1'b0;
    localparam logic REG_NUMBER_COUNT = 1'b1;

    localparam int ENTRY_W = 42;
    localparam int CP_W    = 21;

    // ASCII used by the contraction and space rules
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_E     = 8'h65;

    // UTF-8 limits
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
    localparam logic [7:0] MIN_AFTER_F0 = 8'h90;

    typedef enum logic [1:0] {
        DK_NONE,
        DK_MORE,
        DK_UNIT
    } dec_kind_t;

    typedef struct packed {
        dec_kind_t       kind;
        logic [2:0]      len;
        logic            cp_ok;
        logic [CP_W-1:0] cp;
    } dec_t;

    typedef struct packed {
        logic            start;
        logic            cp_ok;
        logic [CP_W-1:0] cp;
    } cls_req_t;

    typedef struct packed {
        logic done;
        logic letter;
        logic number;
    } cls_rsp_t;

    typedef struct packed {
        logic               letter_we;
        logic               number_we;
        logic [9:0]         index;
        logic [ENTRY_W-1:0] entry;
    } tbl_wr_t;

    function automatic logic is_cont(input logic [7:0] b);
        is_cont = (b & CONT_MASK) == CONT_TAG;
    endfunction

    // avail: bytes present from this offset, saturated at 4
    function automatic dec_t utf8_decode(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] avail, input logic fin);
        dec_t            d;
        logic [2:0]      need;
        logic            ok;
        logic [CP_W-1:0] cp;
        d.kind  = DK_UNIT;
        d.len   = 3'd1;
        d.cp_ok = 1'b0;
        d.cp    = '0;
        ok      = 1'b0;
        cp      = '0;
        if (b0 < 8'h80)                  need = 3'd1;
        else if ((b0 & 8'hE0) == 8'hC0)  need = 3'd2;
        else if ((b0 & 8'hF0) == 8'hE0)  need = 3'd3;
        else if ((b0 & 8'hF8) == 8'hF0)  need = 3'd4;
        else                             need = 3'd0;
        if (avail == 3'd0) begin
            d.kind = DK_NONE;
        end else if (need == 3'd0) begin
            d.kind = DK_UNIT;
        end else if (need > avail) begin
            if (!fin) d.kind = DK_MORE;
        end else begin
            case (need)
                3'd1: begin
                    ok = 1'b1;
                    cp = {13'd0, b0};
                end
                3'd2: begin
                    ok = (b0 >= LEAD2_MIN) && is_cont(b1);
                    cp = {10'd0, b0[4:0], b1[5:0]};
                end
                3'd3: begin
                    ok = is_cont(b1) && is_cont(b2) &&
                         !(b0 == LEAD_E0 && b1 < MIN_AFTER_E0) &&
                         !(b0 == LEAD_ED && b1 >= MIN_AFTER_E0);
                    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                end
                default: begin
                    ok = is_cont(b1) && is_cont(b2) && is_cont(b3) &&
                         !(b0 > LEAD4_MAX) &&
                         !(b0 == LEAD_F0 && b1 < MIN_AFTER_F0) &&
                         !(b0 == LEAD4_MAX && b1 >= MIN_AFTER_F0);
                    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                end
            endcase
            if (ok) begin
                d.len   = need;
                d.cp_ok = 1'b1;
                d.cp    = cp;
            end
        end
        return d;
    endfunction

    function automatic logic is_ws(input logic [CP_W-1:0] cp);
        is_ws = (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h0085 ||
                cp == 21'h00A0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
                cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
                cp == 21'h3000;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/upts_ram.sv
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none

module upts_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/upts_classify.sv
// Letter and number lookup: binary search over the two range tables.
`default_nettype none

module upts_classify #(
    parameter int LETTER_DEPTH = 1024,
    parameter int NUMBER_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire upts_pkg::tbl_wr_t  tbl_wr,
    input  wire logic [10:0]        letter_count,
    input  wire logic [8:0]         number_count,
    input  wire upts_pkg::cls_req_t req,
    output upts_pkg::cls_rsp_t      rsp
);

    localparam int LAW = LETTER_DEPTH > 1 ? $clog2(LETTER_DEPTH) : 1;
    localparam int NAW = NUMBER_DEPTH > 1 ? $clog2(NUMBER_DEPTH) : 1;
    localparam int LCW = $clog2(LETTER_DEPTH + 1);
    localparam int NCW = $clog2(NUMBER_DEPTH + 1);
    localparam int SW  = LCW > NCW ? LCW : NCW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_CMP
    } srch_state_t;

    srch_state_t               state_reg, state_next;
    logic                      sel_num_reg, sel_num_next;
    logic [SW-1:0]             lo_reg, lo_next;
    logic [SW-1:0]             hi_reg, hi_next;
    logic [SW-1:0]             mid_reg, mid_next;
    logic [upts_pkg::CP_W-1:0] cp_reg, cp_next;
    logic                      letter_hit_reg, letter_hit_next;
    upts_pkg::cls_rsp_t        rsp_reg, rsp_next;

    logic [SW-1:0]                    mid_c;
    logic [SW-1:0]                    letter_hi;
    logic [SW-1:0]                    number_hi;
    logic [upts_pkg::ENTRY_W-1:0]     letter_q;
    logic [upts_pkg::ENTRY_W-1:0]     number_q;
    logic [upts_pkg::ENTRY_W-1:0]     row;
    logic [upts_pkg::CP_W-1:0]        row_first;
    logic [upts_pkg::CP_W-1:0]        row_last;
    logic                             hit;
    logic                             miss_done;

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);

    // a count above the depth searches the whole table
    assign letter_hi = (32'(letter_count) > 32'(LETTER_DEPTH)) ? SW'(LETTER_DEPTH)
                                                               : SW'(letter_count);
    assign number_hi = (32'(number_count) > 32'(NUMBER_DEPTH)) ? SW'(NUMBER_DEPTH)
                                                               : SW'(number_count);

    upts_ram #(.WIDTH(upts_pkg::ENTRY_W), .DEPTH(LETTER_DEPTH)) u_letter_ram (
        .aclk    (aclk),
        .wr_en   (tbl_wr.letter_we && (32'(tbl_wr.index) < 32'(LETTER_DEPTH))),
        .wr_addr (LAW'(tbl_wr.index)),
        .wr_data (tbl_wr.entry),
        .rd_addr (mid_c[LAW-1:0]),
        .rd_data (letter_q)
    );

    upts_ram #(.WIDTH(upts_pkg::ENTRY_W), .DEPTH(NUMBER_DEPTH)) u_number_ram (
        .aclk    (aclk),
        .wr_en   (tbl_wr.number_we && (32'(tbl_wr.index) < 32'(NUMBER_DEPTH))),
        .wr_addr (NAW'(tbl_wr.index)),
        .wr_data (tbl_wr.entry),
        .rd_addr (mid_c[NAW-1:0]),
        .rd_data (number_q)
    );

    assign row       = sel_num_reg ? number_q : letter_q;
    assign row_first = row[upts_pkg::CP_W-1:0];
    assign row_last  = row[2*upts_pkg::CP_W-1:upts_pkg::CP_W];

    always_comb begin
        state_next      = state_reg;
        sel_num_next    = sel_num_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        cp_next         = cp_reg;
        letter_hit_next = letter_hit_reg;
        rsp_next        = '0;
        rsp_next.letter = rsp_reg.letter;
        rsp_next.number = rsp_reg.number;
        hit             = 1'b0;
        miss_done       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    if (!req.cp_ok) begin
                        // malformed unit: class other, no lookup
                        rsp_next.done   = 1'b1;
                        rsp_next.letter = 1'b0;
                        rsp_next.number = 1'b0;
                    end else begin
                        cp_next      = req.cp;
                        sel_num_next = 1'b0;
                        lo_next      = '0;
                        hi_next      = letter_hi;
                        state_next   = S_CHK;
                    end
                end
            end
            S_CHK: begin
                // RAM samples mid_c on this edge
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_c;
                    state_next = S_CMP;
                end else begin
                    miss_done = 1'b1;
                end
            end
            S_CMP: begin
                if (cp_reg < row_first) begin
                    hi_next    = mid_reg;
                    state_next = S_CHK;
                end else if (cp_reg > row_last) begin
                    lo_next    = mid_reg + SW'(1);
                    state_next = S_CHK;
                end else begin
                    hit = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (hit || miss_done) begin
            if (!sel_num_reg) begin
                letter_hit_next = hit;
                sel_num_next    = 1'b1;
                lo_next         = '0;
                hi_next         = number_hi;
                state_next      = S_CHK;
            end else begin
                rsp_next.done   = 1'b1;
                rsp_next.letter = letter_hit_reg;
                rsp_next.number = hit;
                state_next      = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rsp_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
        sel_num_reg    <= sel_num_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        cp_reg         <= cp_next;
        letter_hit_reg <= letter_hit_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_pretoken_splitter.sv
// UTF-8 pretoken splitter: echoes text bytes with token-start/text-end flags.
//
// Input stream (s_*): one request per beat. s_tuser selects the kind: a text
// byte, or a write of one letter or number range entry into its table. Table
// writes give no result. s_tlast marks the final text byte.
// Result stream (m_*): one beat per text byte, in input order, flagged with
// token start and end of text; m_tlast marks the last result a request caused.
// Bytes are held back until the rule that owns them is known, so a request
// may give zero to several results; the final byte flushes everything.
// Per text byte the sequencer decodes the held bytes, and every code point
// that needs a class runs two binary searches over the range RAMs, letters
// first and then numbers, each probe taking a check step and a compare step.
// One request is worked on at a time; s_tready is high only between requests.
// A stalled receiver holds the block in its emit or flush step; results sit
// in a one-deep pending stage and the output register, nothing is dropped.
// Reset (synchronous, aresetn low) empties the hold buffer, returns to a
// token start and clears both counts; table contents are kept unknown and
// need no clearing pass. Counts are written over the APB port; the user must
// write them only while idle, which the block itself does not enforce.
`default_nettype none

module utf8_pretoken_splitter #(
    parameter int LETTER_DEPTH = 1024,
    parameter int NUMBER_DEPTH = 256,
    parameter int HOLD_DEPTH   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // byte_value, entry_index, range_first, range_last
    input  wire logic [1:0]  s_tuser,   // func
    input  wire logic        s_tlast,   // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [1:0]       m_tuser,   // token_start, text_end
    output logic             m_tlast,   // run_last
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int HCW = $clog2(HOLD_DEPTH + 1);
    localparam int HIW = $clog2(HOLD_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_SPACE,
        ST_CLS,
        ST_EMIT,
        ST_FLUSH
    } seq_state_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_LETTER,
        PH_DIGIT,
        PH_OTHER,
        PH_WS
    } phase_t;

    typedef enum logic [1:0] {
        POST_LOOP,
        POST_DONE,
        POST_SPACE
    } post_t;

    typedef enum logic [1:0] {
        CTX_PLAIN,
        CTX_SPACE,
        CTX_RUN
    } ctx_t;

    // sequencer state
    seq_state_t         state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         run_cnt_reg, run_cnt_next;
    logic [7:0]         held_reg [HOLD_DEPTH];
    logic [7:0]         held_next [HOLD_DEPTH];
    logic [HCW-1:0]     held_cnt_reg, held_cnt_next;
    logic               fin_reg, fin_next;
    logic [2:0]         emit_left_reg, emit_left_next;
    logic               emit_first_reg, emit_first_next;
    post_t              post_reg, post_next;
    logic [2:0]         unit_len_reg, unit_len_next;
    logic               unit_ws_reg, unit_ws_next;
    ctx_t               ctx_reg, ctx_next;
    upts_pkg::cls_req_t cls_req_reg, cls_req_next;
    // pending result, then output register
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_byte_reg, pend_byte_next;
    logic               pend_start_reg, pend_start_next;
    logic               pend_end_reg, pend_end_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_start_reg, m_start_next;
    logic               m_end_reg, m_end_next;
    logic               m_last_reg, m_last_next;
    // configuration
    logic [10:0]        letter_count_reg, letter_count_next;
    logic [8:0]         number_count_reg, number_count_next;

    upts_pkg::cls_rsp_t cls_rsp;
    upts_pkg::tbl_wr_t  tbl_wr;

    logic               in_acc;
    logic               cfg_wr;
    logic               out_free;
    logic [7:0]         win0 [4];
    logic [7:0]         winx [4];
    logic [2:0]         avail0;
    logic [2:0]         availx;
    logic [HCW-1:0]     remx;
    logic [HCW-1:0]     aux_off;
    logic [2:0]         h_len;
    upts_pkg::dec_t     dec0;
    upts_pkg::dec_t     dec0f;
    upts_pkg::dec_t     decx;
    logic               c1_short;
    logic               c1_long;
    logic               c2_match;
    logic               take;
    phase_t             cls_phase;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == upts_pkg::REG_NUMBER_COUNT) ? {23'd0, number_count_reg}
                                                              : {21'd0, letter_count_reg};

    assign tbl_wr.letter_we = in_acc && (s_tuser == upts_pkg::FUNC_LETTER);
    assign tbl_wr.number_we = in_acc && (s_tuser == upts_pkg::FUNC_NUMBER);
    assign tbl_wr.index     = s_tdata[17:8];
    assign tbl_wr.entry     = {s_tdata[59:39], s_tdata[38:18]};

    upts_classify #(.LETTER_DEPTH(LETTER_DEPTH), .NUMBER_DEPTH(NUMBER_DEPTH)) u_classify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tbl_wr       (tbl_wr),
        .letter_count (letter_count_reg),
        .number_count (number_count_reg),
        .req          (cls_req_reg),
        .rsp          (cls_rsp)
    );

    // decode windows: at the head, and at the space/whitespace lookahead offset
    assign h_len   = (run_cnt_reg == 2'd2) ?
                     ((dec0f.kind == upts_pkg::DK_UNIT) ? dec0f.len : 3'd1) : 3'd0;
    assign aux_off = (phase_reg == PH_WS) ? HCW'(h_len) : HCW'(1);
    assign avail0  = (held_cnt_reg > HCW'(4)) ? 3'd4 : held_cnt_reg[2:0];
    assign remx    = (held_cnt_reg > aux_off) ? held_cnt_reg - aux_off : '0;
    assign availx  = (remx > HCW'(4)) ? 3'd4 : remx[2:0];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            win0[j] = held_reg[j];
            if (int'(aux_off) + j < HOLD_DEPTH) winx[j] = held_reg[HIW'(int'(aux_off) + j)];
            else winx[j] = '0;
        end
    end

    assign dec0  = upts_pkg::utf8_decode(win0[0], win0[1], win0[2], win0[3], avail0, fin_reg);
    assign dec0f = upts_pkg::utf8_decode(win0[0], win0[1], win0[2], win0[3], avail0, 1'b1);
    assign decx  = upts_pkg::utf8_decode(winx[0], winx[1], winx[2], winx[3], availx, fin_reg);

    // contractions: 's 't 'm 'd, and 're 've 'll
    assign c1_short = held_reg[1] == upts_pkg::CH_S || held_reg[1] == upts_pkg::CH_T ||
                      held_reg[1] == upts_pkg::CH_M || held_reg[1] == upts_pkg::CH_D;
    assign c1_long  = held_reg[1] == upts_pkg::CH_R || held_reg[1] == upts_pkg::CH_V ||
                      held_reg[1] == upts_pkg::CH_L;
    assign c2_match = (held_reg[1] != upts_pkg::CH_L && held_reg[2] == upts_pkg::CH_E) ||
                      (held_reg[1] == upts_pkg::CH_L && held_reg[2] == upts_pkg::CH_L);

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (cls_rsp.letter)      cls_phase = PH_LETTER;
        else if (cls_rsp.number) cls_phase = PH_DIGIT;
        else if (unit_ws_reg)    cls_phase = PH_WS;
        else                     cls_phase = PH_OTHER;
        case (phase_reg)
            PH_LETTER: take = cls_rsp.letter;
            PH_DIGIT:  take = cls_rsp.number;
            default:   take = !cls_rsp.letter && !cls_rsp.number && !unit_ws_reg;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        run_cnt_next      = run_cnt_reg;
        held_next         = held_reg;
        held_cnt_next     = held_cnt_reg;
        fin_next          = fin_reg;
        emit_left_next    = emit_left_reg;
        emit_first_next   = emit_first_reg;
        post_next         = post_reg;
        unit_len_next     = unit_len_reg;
        unit_ws_next      = unit_ws_reg;
        ctx_next          = ctx_reg;
        cls_req_next      = cls_req_reg;
        cls_req_next.start = 1'b0;
        pend_valid_next   = pend_valid_reg;
        pend_byte_next    = pend_byte_reg;
        pend_start_next   = pend_start_reg;
        pend_end_next     = pend_end_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_byte_next       = m_byte_reg;
        m_start_next      = m_start_reg;
        m_end_next        = m_end_reg;
        m_last_next       = m_last_reg;
        letter_count_next = letter_count_reg;
        number_count_next = number_count_reg;

        if (cfg_wr) begin
            if (paddr[2] == upts_pkg::REG_LETTER_COUNT) letter_count_next = pwdata[10:0];
            else number_count_next = pwdata[8:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == upts_pkg::FUNC_TEXT) begin
                    if (held_cnt_reg < HCW'(HOLD_DEPTH)) begin
                        held_next[held_cnt_reg[HIW-1:0]] = s_tdata[7:0];
                        held_cnt_next = held_cnt_reg + HCW'(1);
                    end
                    fin_next   = s_tlast;
                    state_next = ST_LOOP;
                end
            end

            ST_LOOP: begin
                case (phase_reg)
                    PH_START: begin
                        if (held_cnt_reg == '0) begin
                            state_next = ST_FLUSH;
                        end else if (held_reg[0] == upts_pkg::CH_APOS &&
                                     held_cnt_reg < HCW'(2) && !fin_reg) begin
                            state_next = ST_FLUSH;
                        end else if (held_reg[0] == upts_pkg::CH_APOS &&
                                     held_cnt_reg >= HCW'(2) && c1_short) begin
                            emit_left_next  = 3'd2;
                            emit_first_next = 1'b1;
                            post_next       = POST_LOOP;
                            state_next      = ST_EMIT;
                        end else if (held_reg[0] == upts_pkg::CH_APOS && c1_long &&
                                     held_cnt_reg == HCW'(2) && !fin_reg) begin
                            state_next = ST_FLUSH;
                        end else if (held_reg[0] == upts_pkg::CH_APOS && c1_long &&
                                     held_cnt_reg >= HCW'(3) && c2_match) begin
                            emit_left_next  = 3'd3;
                            emit_first_next = 1'b1;
                            post_next       = POST_LOOP;
                            state_next      = ST_EMIT;
                        end else if (dec0.kind == upts_pkg::DK_MORE) begin
                            state_next = ST_FLUSH;
                        end else if (held_reg[0] == upts_pkg::CH_SPACE) begin
                            if (decx.kind == upts_pkg::DK_MORE ||
                                (decx.kind == upts_pkg::DK_NONE && !fin_reg)) begin
                                state_next = ST_FLUSH;
                            end else begin
                                emit_left_next  = 3'd1;
                                emit_first_next = 1'b1;
                                post_next       = (decx.kind == upts_pkg::DK_NONE) ?
                                                  POST_LOOP : POST_SPACE;
                                state_next      = ST_EMIT;
                            end
                        end else begin
                            unit_len_next = dec0.len;
                            unit_ws_next  = dec0.cp_ok && upts_pkg::is_ws(dec0.cp);
                            cls_req_next  = '{start: 1'b1, cp_ok: dec0.cp_ok, cp: dec0.cp};
                            ctx_next      = CTX_PLAIN;
                            state_next    = ST_CLS;
                        end
                    end
                    PH_WS: begin
                        // with two in the run, the last whitespace char is still held
                        if (decx.kind == upts_pkg::DK_MORE) begin
                            state_next = ST_FLUSH;
                        end else if (decx.kind == upts_pkg::DK_NONE) begin
                            if (fin_reg && h_len != 3'd0) begin
                                emit_left_next  = h_len;
                                emit_first_next = 1'b0;
                                post_next       = POST_DONE;
                                state_next      = ST_EMIT;
                            end else begin
                                state_next = ST_FLUSH;
                            end
                        end else if (decx.cp_ok && upts_pkg::is_ws(decx.cp)) begin
                            run_cnt_next = 2'd2;
                            if (h_len != 3'd0) begin
                                emit_left_next  = h_len;
                                emit_first_next = 1'b0;
                                post_next       = POST_LOOP;
                                state_next      = ST_EMIT;
                            end
                        end else begin
                            phase_next   = PH_START;
                            run_cnt_next = 2'd0;
                        end
                    end
                    default: begin
                        if (dec0.kind != upts_pkg::DK_UNIT) begin
                            state_next = ST_FLUSH;
                        end else begin
                            unit_len_next = dec0.len;
                            unit_ws_next  = dec0.cp_ok && upts_pkg::is_ws(dec0.cp);
                            cls_req_next  = '{start: 1'b1, cp_ok: dec0.cp_ok, cp: dec0.cp};
                            ctx_next      = CTX_RUN;
                            state_next    = ST_CLS;
                        end
                    end
                endcase
            end

            ST_SPACE: begin
                // the space is out; classify what follows it
                unit_len_next = dec0.len;
                unit_ws_next  = dec0.cp_ok && upts_pkg::is_ws(dec0.cp);
                cls_req_next  = '{start: 1'b1, cp_ok: dec0.cp_ok, cp: dec0.cp};
                ctx_next      = CTX_SPACE;
                state_next    = ST_CLS;
            end

            ST_CLS: begin
                if (cls_rsp.done) begin
                    state_next      = ST_LOOP;
                    emit_left_next  = unit_len_reg;
                    emit_first_next = 1'b0;
                    post_next       = POST_LOOP;
                    case (ctx_reg)
                        CTX_PLAIN: begin
                            phase_next = cls_phase;
                            if (cls_phase == PH_WS) run_cnt_next = 2'd1;
                            emit_first_next = 1'b1;
                            state_next      = ST_EMIT;
                        end
                        CTX_SPACE: begin
                            phase_next = cls_phase;
                            if (cls_phase == PH_WS) run_cnt_next = 2'd1;
                            else state_next = ST_EMIT;
                        end
                        default: begin
                            if (take) state_next = ST_EMIT;
                            else phase_next = PH_START;
                        end
                    endcase
                end
            end

            ST_EMIT: begin
                if (emit_left_reg == 3'd0 || held_cnt_reg == '0) begin
                    case (post_reg)
                        POST_DONE:  state_next = ST_FLUSH;
                        POST_SPACE: state_next = ST_SPACE;
                        default:    state_next = ST_LOOP;
                    endcase
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = pend_byte_reg;
                        m_start_next = pend_start_reg;
                        m_end_next   = pend_end_reg;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_byte_next  = held_reg[0];
                    pend_start_next = emit_first_reg;
                    pend_end_next   = fin_reg && held_cnt_reg == HCW'(1);
                    for (int i = 0; i < HOLD_DEPTH - 1; i++) held_next[i] = held_reg[i + 1];
                    held_cnt_next   = held_cnt_reg - HCW'(1);
                    emit_left_next  = emit_left_reg - 3'd1;
                    emit_first_next = 1'b0;
                end
            end

            ST_FLUSH: begin
                if (fin_reg) begin
                    phase_next    = PH_START;
                    run_cnt_next  = 2'd0;
                    held_cnt_next = '0;
                end
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_byte_next     = pend_byte_reg;
                    m_start_next    = pend_start_reg;
                    m_end_next      = pend_end_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_START;
            run_cnt_reg      <= 2'd0;
            held_cnt_reg     <= '0;
            cls_req_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            letter_count_reg <= '0;
            number_count_reg <= '0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            run_cnt_reg      <= run_cnt_next;
            held_cnt_reg     <= held_cnt_next;
            cls_req_reg      <= cls_req_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
            letter_count_reg <= letter_count_next;
            number_count_reg <= number_count_next;
        end
        held_reg       <= held_next;
        fin_reg        <= fin_next;
        emit_left_reg  <= emit_left_next;
        emit_first_reg <= emit_first_next;
        post_reg       <= post_next;
        unit_len_reg   <= unit_len_next;
        unit_ws_reg    <= unit_ws_next;
        ctx_reg        <= ctx_next;
        pend_byte_reg  <= pend_byte_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        m_byte_reg     <= m_byte_next;
        m_start_reg    <= m_start_next;
        m_end_reg      <= m_end_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_end_reg, m_start_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
